// ===== design/kwm_pkg.sv =====
// shared types, field widths and codes of the k-way time merge
`default_nettype none

package kwm_pkg;

    localparam int LANES_DEFAULT      = 8;
    localparam int LANE_DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH        = 2;

    localparam int KIND_W       = 2;
    localparam int LANE_FIELD_W = 3;
    localparam int TIME_W       = 64;
    localparam int POS_W        = 8;
    localparam int RUN_LEN_W    = 9;

    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = KIND_W;
    localparam int OUT_DATA_W = 160;
    localparam int OUT_USER_W = 3;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_STEP   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    lane_ok;
        logic [LANE_FIELD_W-1:0] lane;
        logic [TIME_W-1:0]       rec_time;
        logic [TIME_W-1:0]       rec_fact;
    } cmd_t;

    typedef struct packed {
        logic                    status;
        logic                    have_winner;
        logic [LANE_FIELD_W-1:0] win_lane;
        logic [TIME_W-1:0]       win_time;
        logic [TIME_W-1:0]       win_fact;
        logic [POS_W-1:0]        win_pos;
        logic                    run_closed;
        logic [LANE_FIELD_W-1:0] run_lane;
        logic [POS_W-1:0]        run_start;
        logic [RUN_LEN_W-1:0]    run_length;
    } res_t;

endpackage

`default_nettype wire

// ===== design/k_way_time_merge.sv =====
// top level of the k-way time merge engine
`default_nettype none

// Merges LANES sorted record lanes held in on-chip memory. A word with tuser 0 appends
// a (time, fact) record to a lane, tuser 1 pops the head with the smallest time (larger
// fact, then lower lane, on ties) and reports runs of picks from one lane, tuser 2
// empties all lanes. Every word gives exactly one result word. Words pass a two-entry
// queue to the execution side, which holds each lane's head record in flip-flops and
// feeds a compare tree with one register level per stage, clog2(LANES) levels. Append,
// clear and unused kinds do not wait on the tree. When the popped lane still holds
// records, the next head is read from the record memory and then ripples up the tree
// before the next step; when the lane runs dry only the ripple is waited for, and a step
// that finds every lane exhausted holds off nothing. An append into an empty lane or a
// clear holds off the next step until the tree has settled, as does reset for the first
// step. A result that waits on m_tready holds the execution side until it is taken;
// words keep entering the queue until it fills. The record memories need no clearing
// after reset.
module k_way_time_merge #(
    parameter int LANES      = kwm_pkg::LANES_DEFAULT,
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // lane, rec_time, rec_fact
    input  wire logic [kwm_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [kwm_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // win_lane, win_time, win_fact, win_pos, run_lane, run_start, run_length
    output logic      [kwm_pkg::OUT_DATA_W-1:0] m_tdata,
    // status, have_winner, run_closed
    output logic      [kwm_pkg::OUT_USER_W-1:0] m_tuser
);

    kwm_pkg::cmd_t front_cmd;
    kwm_pkg::cmd_t queue_cmd;
    kwm_pkg::res_t res;
    logic          front_push;
    logic          queue_full;
    logic          queue_valid;
    logic          queue_pop;

    kwm_front #(
        .LANES (LANES)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (front_push),
        .cmd        (front_cmd)
    );

    kwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_valid (queue_valid),
        .pop_data  (queue_cmd)
    );

    kwm_back #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tuser = {res.run_closed, res.have_winner, res.status};
    assign m_tdata = {1'b0, res.run_length, res.run_start, res.run_lane,
                      res.win_pos, res.win_fact, res.win_time, res.win_lane};

endmodule

`default_nettype wire

// ===== design/kwm_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/kwm_tree.sv =====
// registered compare tree that finds the winning lane head, with a register at every node
`default_nettype none

module kwm_tree #(
    parameter int LANES      = kwm_pkg::LANES_DEFAULT,
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEFAULT
) (
    input  wire logic                                        clk,
    input  wire logic [LANES-1:0]                            leaf_valid,
    input  wire logic [LANES-1:0][kwm_pkg::TIME_W-1:0]       leaf_time,
    input  wire logic [LANES-1:0][kwm_pkg::TIME_W-1:0]       leaf_fact,
    input  wire logic [LANES-1:0][$clog2(LANE_DEPTH)-1:0]    leaf_pos,
    output logic                                             root_valid,
    output logic      [kwm_pkg::TIME_W-1:0]                  root_time,
    output logic      [kwm_pkg::TIME_W-1:0]                  root_fact,
    output logic      [$clog2(LANES)-1:0]                    root_lane,
    output logic      [$clog2(LANE_DEPTH)-1:0]               root_pos
);

    localparam int TIME_W = kwm_pkg::TIME_W;
    localparam int LANE_W = $clog2(LANES);
    localparam int IDX_W  = $clog2(LANE_DEPTH);
    localparam int LEAVES = 1 << LANE_W;
    localparam int NODES  = 2 * LEAVES - 1;

    // heap order: node n has children 2n+1 and 2n+2, leaves from LEAVES-1 up
    logic              all_valid [NODES];
    logic [TIME_W-1:0] all_time  [NODES];
    logic [TIME_W-1:0] all_fact  [NODES];
    logic [LANE_W-1:0] all_lane  [NODES];
    logic [IDX_W-1:0]  all_pos   [NODES];

    genvar k;
    generate
        for (k = 0; k < LEAVES; k++)
        begin : g_leaf
            if (k < LANES)
            begin : g_live
                assign all_valid[LEAVES-1+k] = leaf_valid[k];
                assign all_time[LEAVES-1+k]  = leaf_time[k];
                assign all_fact[LEAVES-1+k]  = leaf_fact[k];
                assign all_pos[LEAVES-1+k]   = leaf_pos[k];
            end
            else
            begin : g_pad
                assign all_valid[LEAVES-1+k] = 1'b0;
                assign all_time[LEAVES-1+k]  = '0;
                assign all_fact[LEAVES-1+k]  = '0;
                assign all_pos[LEAVES-1+k]   = '0;
            end
            assign all_lane[LEAVES-1+k] = LANE_W'(k);
        end

        for (k = 0; k < LEAVES - 1; k++)
        begin : g_node
            logic              node_valid_reg;
            logic [TIME_W-1:0] node_time_reg;
            logic [TIME_W-1:0] node_fact_reg;
            logic [LANE_W-1:0] node_lane_reg;
            logic [IDX_W-1:0]  node_pos_reg;
            logic              take_right;

            // right side only wins on a strictly better key, so lower lanes win full ties
            always_comb
            begin
                take_right = all_valid[2*k+2] &&
                    (!all_valid[2*k+1] ||
                     ($signed(all_time[2*k+2]) < $signed(all_time[2*k+1])) ||
                     ((all_time[2*k+2] == all_time[2*k+1]) &&
                      ($signed(all_fact[2*k+2]) > $signed(all_fact[2*k+1]))));
            end

            always_ff @(posedge clk)
            begin
                if (take_right)
                begin
                    node_valid_reg <= all_valid[2*k+2];
                    node_time_reg  <= all_time[2*k+2];
                    node_fact_reg  <= all_fact[2*k+2];
                    node_lane_reg  <= all_lane[2*k+2];
                    node_pos_reg   <= all_pos[2*k+2];
                end
                else
                begin
                    node_valid_reg <= all_valid[2*k+1];
                    node_time_reg  <= all_time[2*k+1];
                    node_fact_reg  <= all_fact[2*k+1];
                    node_lane_reg  <= all_lane[2*k+1];
                    node_pos_reg   <= all_pos[2*k+1];
                end
            end

            assign all_valid[k] = node_valid_reg;
            assign all_time[k]  = node_time_reg;
            assign all_fact[k]  = node_fact_reg;
            assign all_lane[k]  = node_lane_reg;
            assign all_pos[k]   = node_pos_reg;
        end
    endgenerate

    assign root_valid = all_valid[0];
    assign root_time  = all_time[0];
    assign root_fact  = all_fact[0];
    assign root_lane  = all_lane[0];
    assign root_pos   = all_pos[0];

endmodule

`default_nettype wire

// ===== design/kwm_queue.sv =====
// short command queue between the front and back ends
`default_nettype none

module kwm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire kwm_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               pop_valid,
    output kwm_pkg::cmd_t      pop_data
);

    localparam int DEPTH = kwm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    kwm_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/kwm_front.sv =====
// input side: takes words, decodes the kind and checks the lane range
`default_nettype none

module kwm_front #(
    parameter int LANES = kwm_pkg::LANES_DEFAULT
) (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [kwm_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [kwm_pkg::IN_USER_W-1:0] s_tuser,
    input  wire logic                          queue_full,
    output logic                               push,
    output kwm_pkg::cmd_t                      cmd
);

    localparam int LF_W   = kwm_pkg::LANE_FIELD_W;
    localparam int TIME_W = kwm_pkg::TIME_W;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        cmd.lane     = s_tdata[LF_W-1:0];
        cmd.rec_time = s_tdata[LF_W +: TIME_W];
        cmd.rec_fact = s_tdata[LF_W + TIME_W +: TIME_W];
        cmd.lane_ok  = (int'(cmd.lane) < LANES);
        case (s_tuser)
            kwm_pkg::KIND_APPEND: cmd.op = kwm_pkg::OP_APPEND;
            kwm_pkg::KIND_STEP:   cmd.op = kwm_pkg::OP_STEP;
            kwm_pkg::KIND_CLEAR:  cmd.op = kwm_pkg::OP_CLEAR;
            default:              cmd.op = kwm_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/kwm_back.sv =====
// execution side: lane stores, head cache, winner tree, run tracking and result register
`default_nettype none

module kwm_back #(
    parameter int LANES      = kwm_pkg::LANES_DEFAULT,
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire kwm_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    input  wire logic          res_ready,
    output kwm_pkg::res_t      res
);

    localparam int TIME_W    = kwm_pkg::TIME_W;
    localparam int LF_W      = kwm_pkg::LANE_FIELD_W;
    localparam int POS_W     = kwm_pkg::POS_W;
    localparam int RUN_W     = kwm_pkg::RUN_LEN_W;
    localparam int LANE_W    = $clog2(LANES);
    localparam int IDX_W     = $clog2(LANE_DEPTH);
    localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
    localparam int LEVELS    = $clog2(LANES);
    localparam int SET_W     = $clog2(LEVELS + 1);
    localparam int ADDR_W    = LANE_W + IDX_W;
    localparam int RAM_DEPTH = LANES * (2 ** IDX_W);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_FILL = 2'b10
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [LANES-1:0][CNT_W-1:0]       fill_reg;
    logic [LANES-1:0][CNT_W-1:0]       fill_next;
    logic [LANES-1:0][CNT_W-1:0]       head_reg;
    logic [LANES-1:0][CNT_W-1:0]       head_next;
    logic [LANES-1:0]                  cache_valid_reg;
    logic [LANES-1:0]                  cache_valid_next;
    logic [LANES-1:0][TIME_W-1:0]      cache_time_reg;
    logic [LANES-1:0][TIME_W-1:0]      cache_time_next;
    logic [LANES-1:0][TIME_W-1:0]      cache_fact_reg;
    logic [LANES-1:0][TIME_W-1:0]      cache_fact_next;
    logic [LANES-1:0][IDX_W-1:0]       cache_pos_reg;
    logic [LANES-1:0][IDX_W-1:0]       cache_pos_next;
    logic [LANE_W-1:0]                 pend_lane_reg;
    logic [LANE_W-1:0]                 pend_lane_next;
    logic [IDX_W-1:0]                  pend_start_reg;
    logic [IDX_W-1:0]                  pend_start_next;
    logic [CNT_W-1:0]                  pend_len_reg;
    logic [CNT_W-1:0]                  pend_len_next;
    logic [SET_W-1:0]                  settle_reg;
    logic [SET_W-1:0]                  settle_next;
    logic [LANE_W-1:0]                 refill_lane_reg;
    logic [LANE_W-1:0]                 refill_lane_next;
    logic [IDX_W-1:0]                  refill_pos_reg;
    logic [IDX_W-1:0]                  refill_pos_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    kwm_pkg::res_t                     res_reg;
    kwm_pkg::res_t                     res_next;

    logic [LANES-1:0]                  empty_vec;
    logic [LANES-1:0]                  more_vec;
    logic                              fire;
    logic [LANE_W-1:0]                 lane_sel;
    logic [CNT_W-1:0]                  app_fill;
    logic                              app_full;
    logic                              close_run;
    logic [CNT_W-1:0]                  next_pos;

    logic                              ram_wr_en;
    logic [ADDR_W-1:0]                 ram_wr_addr;
    logic                              ram_rd_en;
    logic [ADDR_W-1:0]                 ram_rd_addr;
    logic [TIME_W-1:0]                 ram_time_rd;
    logic [TIME_W-1:0]                 ram_fact_rd;

    logic                              root_valid;
    logic [TIME_W-1:0]                 root_time;
    logic [TIME_W-1:0]                 root_fact;
    logic [LANE_W-1:0]                 root_lane;
    logic [IDX_W-1:0]                  root_pos;

    kwm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RAM_DEPTH)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd.rec_time),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_time_rd)
    );

    kwm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RAM_DEPTH)
    ) u_fact_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd.rec_fact),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_fact_rd)
    );

    kwm_tree #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_tree (
        .clk        (clk),
        .leaf_valid (cache_valid_reg),
        .leaf_time  (cache_time_reg),
        .leaf_fact  (cache_fact_reg),
        .leaf_pos   (cache_pos_reg),
        .root_valid (root_valid),
        .root_time  (root_time),
        .root_fact  (root_fact),
        .root_lane  (root_lane),
        .root_pos   (root_pos)
    );

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            empty_vec[i] = (head_reg[i] == fill_reg[i]);
            more_vec[i]  = ((CNT_W + 1)'(head_reg[i]) + 1'b1) < (CNT_W + 1)'(fill_reg[i]);
        end
    end

    assign lane_sel  = cmd.lane_ok ? LANE_W'(cmd.lane) : '0;
    assign app_fill  = fill_reg[lane_sel];
    assign app_full  = !cmd.lane_ok || (app_fill == CNT_W'(LANE_DEPTH));
    assign close_run = (pend_len_reg != '0) && (!root_valid || (pend_lane_reg != root_lane));
    assign next_pos  = CNT_W'(root_pos) + 1'b1;

    // a step waits until the tree has caught up with the last head change
    assign fire = (state_reg == ST_RUN) && cmd_valid && (!out_valid_reg || res_ready) &&
                  ((cmd.op != kwm_pkg::OP_STEP) || (settle_reg == '0));
    assign cmd_pop = fire;

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        head_next        = head_reg;
        cache_valid_next = cache_valid_reg;
        cache_time_next  = cache_time_reg;
        cache_fact_next  = cache_fact_reg;
        cache_pos_next   = cache_pos_reg;
        pend_lane_next   = pend_lane_reg;
        pend_start_next  = pend_start_reg;
        pend_len_next    = pend_len_reg;
        refill_lane_next = refill_lane_reg;
        refill_pos_next  = refill_pos_reg;
        settle_next      = (settle_reg != '0) ? settle_reg - 1'b1 : settle_reg;
        res_next         = res_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = {lane_sel, app_fill[IDX_W-1:0]};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = {root_lane, next_pos[IDX_W-1:0]};

        if (state_reg == ST_FILL)
        begin
            cache_valid_next[refill_lane_reg] = 1'b1;
            cache_time_next[refill_lane_reg]  = ram_time_rd;
            cache_fact_next[refill_lane_reg]  = ram_fact_rd;
            cache_pos_next[refill_lane_reg]   = refill_pos_reg;
            settle_next                       = SET_W'(LEVELS);
            state_next                        = ST_RUN;
        end
        else if (fire)
        begin
            res_next = '0;
            case (cmd.op)
                kwm_pkg::OP_APPEND:
                begin
                    res_next.status = app_full;
                    if (!app_full)
                    begin
                        ram_wr_en           = 1'b1;
                        fill_next[lane_sel] = app_fill + 1'b1;
                        // empty lane: the new record is its head straight away
                        if (empty_vec[lane_sel])
                        begin
                            cache_valid_next[lane_sel] = 1'b1;
                            cache_time_next[lane_sel]  = cmd.rec_time;
                            cache_fact_next[lane_sel]  = cmd.rec_fact;
                            cache_pos_next[lane_sel]   = app_fill[IDX_W-1:0];
                            settle_next                = SET_W'(LEVELS);
                        end
                    end
                end
                kwm_pkg::OP_STEP:
                begin
                    if (close_run)
                    begin
                        res_next.run_closed = 1'b1;
                        res_next.run_lane   = LF_W'(pend_lane_reg);
                        res_next.run_start  = POS_W'(pend_start_reg);
                        res_next.run_length = RUN_W'(pend_len_reg);
                        pend_len_next       = '0;
                    end
                    if (root_valid)
                    begin
                        res_next.have_winner = 1'b1;
                        res_next.win_lane    = LF_W'(root_lane);
                        res_next.win_time    = root_time;
                        res_next.win_fact    = root_fact;
                        res_next.win_pos     = POS_W'(root_pos);
                        if (close_run || (pend_len_reg == '0))
                        begin
                            pend_lane_next  = root_lane;
                            pend_start_next = root_pos;
                            pend_len_next   = CNT_W'(1);
                        end
                        else
                        begin
                            pend_len_next = pend_len_reg + 1'b1;
                        end
                        head_next[root_lane]        = next_pos;
                        cache_valid_next[root_lane] = 1'b0;
                        if (more_vec[root_lane])
                        begin
                            ram_rd_en        = 1'b1;
                            refill_lane_next = root_lane;
                            refill_pos_next  = next_pos[IDX_W-1:0];
                            state_next       = ST_FILL;
                        end
                        else
                        begin
                            settle_next = SET_W'(LEVELS);
                        end
                    end
                end
                kwm_pkg::OP_CLEAR:
                begin
                    fill_next        = '0;
                    head_next        = '0;
                    cache_valid_next = '0;
                    pend_lane_next   = '0;
                    pend_len_next    = '0;
                    settle_next      = SET_W'(LEVELS);
                end
                default:
                begin
                end
            endcase
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            fill_reg        <= '0;
            head_reg        <= '0;
            cache_valid_reg <= '0;
            pend_lane_reg   <= '0;
            pend_len_reg    <= '0;
            settle_reg      <= SET_W'(LEVELS);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            head_reg        <= head_next;
            cache_valid_reg <= cache_valid_next;
            pend_lane_reg   <= pend_lane_next;
            pend_len_reg    <= pend_len_next;
            settle_reg      <= settle_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cache_time_reg  <= cache_time_next;
        cache_fact_reg  <= cache_fact_next;
        cache_pos_reg   <= cache_pos_next;
        pend_start_reg  <= pend_start_next;
        refill_lane_reg <= refill_lane_next;
        refill_pos_reg  <= refill_pos_next;
        res_reg         <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== design/kwm_checker.sv =====
// port-level checks of the merge engine and their binding to the top level
`default_nettype none

module kwm_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [kwm_pkg::IN_DATA_W-1:0]  s_tdata,
    input wire logic [kwm_pkg::IN_USER_W-1:0]  s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [kwm_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [kwm_pkg::OUT_USER_W-1:0] m_tuser
);

    localparam int WIN_W   = kwm_pkg::LANE_FIELD_W + 2 * kwm_pkg::TIME_W + kwm_pkg::POS_W;
    localparam int RUN_LSB = WIN_W;
    localparam int LEN_LSB = WIN_W + kwm_pkg::LANE_FIELD_W + kwm_pkg::POS_W;
    localparam int RUN_W   = kwm_pkg::LANE_FIELD_W + kwm_pkg::POS_W + kwm_pkg::RUN_LEN_W;

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_refused_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tuser[2:1] == 2'b00) && (m_tdata == '0))
        else $error("refused append carries step fields");

    a_no_winner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[WIN_W-1:0] == '0))
        else $error("winner fields set without a winner");

    a_run_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> (m_tdata[RUN_LSB +: RUN_W] == '0))
        else $error("run fields set without a closed run");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tdata[LEN_LSB +: kwm_pkg::RUN_LEN_W] != '0))
        else $error("closed run has zero length");

endmodule

bind k_way_time_merge kwm_checker u_checker (.*);

`default_nettype wire

// ===== dv/kwm_merge_monitor.sv =====
`timescale 1ns / 100ps
// bus monitor of the k-way time merge: predicts each result word and compares it

module kwm_merge_monitor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    // lane, rec_time, rec_fact
    input  wire logic [kwm_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [kwm_pkg::IN_USER_W-1:0]  s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // win_lane, win_time, win_fact, win_pos, run_lane, run_start, run_length
    input  wire logic [kwm_pkg::OUT_DATA_W-1:0] m_tdata,
    // status, have_winner, run_closed
    input  wire logic [kwm_pkg::OUT_USER_W-1:0] m_tuser,
    output int                                  due_count,
    output int                                  fail_count
);
    import kwm_pkg::*;

    localparam int LANES      = LANES_DEFAULT;
    localparam int LANE_DEPTH = LANE_DEPTH_DEFAULT;

    logic [TIME_W-1:0] lane_time [LANES][LANE_DEPTH];
    logic [TIME_W-1:0] lane_fact [LANES][LANE_DEPTH];
    int                lane_fill [LANES];
    int                lane_head [LANES];
    int                run_lane;
    int                run_len;
    int                fails;
    res_t              due_merge_results [$];

    function automatic res_t predict_merge(input logic [KIND_W-1:0] kind,
                                           input logic [LANE_FIELD_W-1:0] lane,
                                           input logic [TIME_W-1:0] rt,
                                           input logic [TIME_W-1:0] rf);
        res_t               r;
        logic               found;
        int                 win;
        int                 i;
        logic signed [63:0] cur_t;
        logic signed [63:0] cur_f;
        logic signed [63:0] best_t;
        logic signed [63:0] best_f;
        r      = '0;
        found  = 1'b0;
        win    = 0;
        best_t = '0;
        best_f = '0;
        case (op_t'(kind))
            OP_APPEND:
            begin
                if (lane_fill[lane] >= LANE_DEPTH)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    lane_time[lane][lane_fill[lane]] = rt;
                    lane_fact[lane][lane_fill[lane]] = rf;
                    lane_fill[lane]++;
                end
            end
            OP_STEP:
            begin
                for (i = 0; i < LANES; i++)
                begin
                    if (lane_head[i] < lane_fill[i])
                    begin
                        cur_t = lane_time[i][lane_head[i]];
                        cur_f = lane_fact[i][lane_head[i]];
                        if (!found || cur_t < best_t || (cur_t == best_t && cur_f > best_f))
                        begin
                            best_t = cur_t;
                            best_f = cur_f;
                            win    = i;
                        end
                        found = 1'b1;
                    end
                end
                if (run_len > 0 && (!found || run_lane != win))
                begin
                    r.run_closed = 1'b1;
                    r.run_lane   = LANE_FIELD_W'(run_lane);
                    r.run_start  = POS_W'(lane_head[run_lane] - run_len);
                    r.run_length = RUN_LEN_W'(run_len);
                    run_len      = 0;
                end
                if (found)
                begin
                    r.have_winner = 1'b1;
                    r.win_lane    = LANE_FIELD_W'(win);
                    r.win_time    = best_t;
                    r.win_fact    = best_f;
                    r.win_pos     = POS_W'(lane_head[win]);
                    run_lane      = win;
                    run_len++;
                    lane_head[win]++;
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < LANES; i++)
                begin
                    lane_fill[i] = 0;
                    lane_head[i] = 0;
                end
                run_lane = 0;
                run_len  = 0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic string describe(input res_t r);
        return $sformatf("st %b win %b lane %0d time %h fact %h pos %0d | run %b lane %0d start %0d len %0d",
                         r.status, r.have_winner, r.win_lane, r.win_time, r.win_fact, r.win_pos,
                         r.run_closed, r.run_lane, r.run_start, r.run_length);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        int   i;
        if (!rst_n)
        begin
            for (i = 0; i < LANES; i++)
            begin
                lane_fill[i] = 0;
                lane_head[i] = 0;
            end
            run_lane = 0;
            run_len  = 0;
            fails    = 0;
            due_merge_results.delete();
            due_count  <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status      = m_tuser[0];
                got.have_winner = m_tuser[1];
                got.run_closed  = m_tuser[2];
                got.win_lane    = m_tdata[2:0];
                got.win_time    = m_tdata[66:3];
                got.win_fact    = m_tdata[130:67];
                got.win_pos     = m_tdata[138:131];
                got.run_lane    = m_tdata[141:139];
                got.run_start   = m_tdata[149:142];
                got.run_length  = m_tdata[158:150];
                if (due_merge_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result word with nothing pending: %s", $time, describe(got));
                end
                else
                begin
                    want = due_merge_results.pop_front();
                    if (got.status !== want.status || got.have_winner !== want.have_winner ||
                        got.win_lane !== want.win_lane || got.win_time !== want.win_time ||
                        got.win_fact !== want.win_fact || got.win_pos !== want.win_pos ||
                        got.run_closed !== want.run_closed || got.run_lane !== want.run_lane ||
                        got.run_start !== want.run_start || got.run_length !== want.run_length)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("%0t: mismatch, expected %s", $time, describe(want));
                            $display("%0t:           actual   %s", $time, describe(got));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_merge_results.push_back(predict_merge(s_tuser, s_tdata[2:0], s_tdata[66:3],
                                                          s_tdata[130:67]));
            due_count  <= due_merge_results.size();
            fail_count <= fails;
        end
    end

endmodule

// ===== dv/tb_k_way_time_merge.sv =====
`timescale 1ns / 100ps
// testbench top of the k-way time merge: stimulus, idling and verdict

module tb_k_way_time_merge;
    import kwm_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] T_MIN          = 64'h8000_0000_0000_0000;
    localparam logic [63:0] T_MAX          = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    int tx_idle_pct  = 23;
    int rx_idle_pct  = 67;
    int words_sent   = 0;
    int stall_cycles = 0;
    int due_count;
    int fail_count;
    int full_lane;
    int i;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    k_way_time_merge u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    kwm_merge_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .due_count  (due_count),
        .fail_count (fail_count)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // mix of tie-prone small values, extremes and full-width values
    function automatic logic [63:0] pick_value();
        int                 near_zero;
        logic signed [63:0] wide;
        near_zero = int'($urandom_range(0, 8)) - 4;
        wide      = 64'(near_zero);
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return wide;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return T_MIN;
                    1: return T_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return 64'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_word(input op_t op, input logic [LANE_FIELD_W-1:0] lane,
                             input logic [63:0] rt, input logic [63:0] rf);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, rf, rt, lane};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    // appends into a window of neighboring lanes, then n to n+2 more words, mostly steps with some appends
    task automatic merge_burst();
        int n;
        int base;
        int spread;
        n      = $urandom_range(1, 10);
        base   = $urandom_range(0, 7);
        spread = $urandom_range(0, 7);
        case ($urandom_range(0, 19))
            0, 1: send_word(OP_CLEAR, 3'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
            2: send_word(OP_NONE, 3'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
            3: send_word(OP_STEP, 3'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
            default:
            begin
            end
        endcase
        repeat (n)
            send_word(OP_APPEND, 3'(base + $urandom_range(0, spread)), pick_value(), pick_value());
        repeat (n + $urandom_range(0, 2))
        begin
            if ($urandom_range(99) < 15)
                send_word(OP_APPEND, 3'(base + $urandom_range(0, spread)), pick_value(),
                          pick_value());
            else
                send_word(OP_STEP, 3'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with every lane empty
        send_word(OP_STEP, 3'd0, '0, '0);
        // time ties, fact ties and a full tie between lanes
        send_word(OP_APPEND, 3'd0, T_MIN, '0);
        send_word(OP_APPEND, 3'd7, T_MAX, T_MAX);
        send_word(OP_APPEND, 3'd3, T_MIN, '1);
        send_word(OP_APPEND, 3'd5, T_MIN, '0);
        send_word(OP_APPEND, 3'd2, '0, T_MIN);
        send_word(OP_NONE, 3'd7, T_MAX, T_MIN);
        repeat (6)
            send_word(OP_STEP, 3'd0, '0, '0);
        // run that keeps going across an append
        send_word(OP_APPEND, 3'd4, 64'd1, 64'd5);
        send_word(OP_APPEND, 3'd4, 64'd2, 64'd6);
        send_word(OP_STEP, 3'd0, '0, '0);
        send_word(OP_APPEND, 3'd4, 64'd3, 64'd7);
        send_word(OP_STEP, 3'd0, '0, '0);
        send_word(OP_STEP, 3'd0, '0, '0);
        send_word(OP_APPEND, 3'd1, -64'sd5, '0);
        send_word(OP_STEP, 3'd0, '0, '0);
        // clear drops the open run
        send_word(OP_CLEAR, 3'd0, '0, '0);
        send_word(OP_STEP, 3'd0, '0, '0);

        while (words_sent < 150)
            merge_burst();
        wait_drained();

        tx_idle_pct = 67;
        rx_idle_pct = 23;
        while (words_sent < 280)
            merge_burst();
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // fill one lane past its depth, then drain it as one long run
        send_word(OP_CLEAR, 3'd0, '0, '0);
        full_lane = $urandom_range(0, 7);
        for (i = 0; i < LANE_DEPTH_DEFAULT + 2; i++)
            send_word(OP_APPEND, 3'(full_lane), T_MIN + 64'(i), {$urandom, $urandom});
        repeat (LANE_DEPTH_DEFAULT + 1)
            send_word(OP_STEP, 3'd0, '0, '0);
        while (words_sent < 850)
            merge_burst();

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kwm_pkg.sv
design/kwm_ram.sv
design/kwm_tree.sv
design/kwm_queue.sv
design/kwm_front.sv
design/kwm_back.sv
design/k_way_time_merge.sv
design/kwm_checker.sv
dv/kwm_merge_monitor.sv
dv/tb_k_way_time_merge.sv
